// ===== design/point_lighting_shader_macros.svh =====
// Assertion macros for the point lighting shader
`ifndef POINT_LIGHTING_SHADER_MACROS_SVH
`define POINT_LIGHTING_SHADER_MACROS_SVH
`ifndef ASSERT_OFF
`define PLS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pls assertion failed");
`define PLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pls assertion failed");
`else
`define PLS_ASSERT_SAME(lbl, ante, cons)
`define PLS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/pls_pkg.sv =====
// Shared types, constants and arithmetic helpers of the point lighting shader
package pls_pkg;

    localparam int VB    = 16;              // input component width
    localparam int F     = 15;              // fraction bits
    localparam int EB    = 10;              // exponent bits used
    localparam int ONE   = 1 << F;
    localparam int HALF  = 1 << (F - 1);
    localparam int UW    = F + 2;           // signed unit component
    localparam int NW    = UW + 1;          // normalizer input (sum of two units)
    localparam int MW    = NW - 1;          // magnitude width
    localparam int AW    = 30;              // magnitude after alignment to 2^29
    localparam int TOPB  = AW - 1;
    localparam int SQW   = 2 * AW + 3;      // square sum and root work width
    localparam int RT_N  = (SQW + 1) / 2;   // root steps
    localparam int LW    = AW + 1;          // length width
    localparam int QW    = F + 2;           // quotient width
    localparam int NUMW  = AW + F + 1;      // dividend width
    localparam int DVW   = NUMW + 2;        // compare width in the divider
    localparam int PRW   = 2 * UW;          // unit product
    localparam int DW    = PRW + 2;         // dot product
    localparam int RW    = DW - F + 1;      // rounded dot product
    localparam int CW    = F + 1;           // clamped cosine
    localparam int PW    = 2 * CW;
    localparam int CLW   = 16;              // color / gain channel width
    localparam int CL_SH = 15;
    localparam int CL_HALF = 1 << (CL_SH - 1);
    localparam int TW    = CLW + 1;         // one term
    localparam int SUMW  = TW + 2;

    localparam logic [2:0] REG_AMB_COLOR = 3'd0;
    localparam logic [2:0] REG_DIF_COLOR = 3'd1;
    localparam logic [2:0] REG_SPC_COLOR = 3'd2;
    localparam logic [2:0] REG_AMB_GAIN  = 3'd3;
    localparam logic [2:0] REG_DIF_GAIN  = 3'd4;
    localparam logic [2:0] REG_SPC_GAIN  = 3'd5;
    localparam logic [2:0] REG_EXPONENT  = 3'd6;
    localparam logic [2:0] REG_MODEL     = 3'd7;

    localparam logic MODEL_BLINN = 1'b0;
    localparam logic MODEL_PHONG = 1'b1;

    typedef logic signed [UW-1:0] unit_t;
    typedef unit_t [2:0] uvec_t;
    typedef logic signed [NW-1:0] nin_t;
    typedef nin_t [2:0] nvec_t;

    typedef struct packed {
        uvec_t nn;
        uvec_t ll;
        uvec_t vv;
    } ctx_t;

    typedef struct packed {
        logic [3*CLW-1:0] amb_color;
        logic [3*CLW-1:0] dif_color;
        logic [3*CLW-1:0] spc_color;
        logic [CLW-1:0]   amb_gain;
        logic [CLW-1:0]   dif_gain;
        logic [CLW-1:0]   spc_gain;
    } cfg_t;

    typedef struct packed {
        logic signed [VB-1:0] normal_x;
        logic signed [VB-1:0] normal_y;
        logic signed [VB-1:0] normal_z;
        logic signed [VB-1:0] light_x;
        logic signed [VB-1:0] light_y;
        logic signed [VB-1:0] light_z;
        logic signed [VB-1:0] eye_x;
        logic signed [VB-1:0] eye_y;
        logic signed [VB-1:0] eye_z;
    } frag_t;

    typedef struct packed {
        logic [CLW-1:0] red;
        logic [CLW-1:0] green;
        logic [CLW-1:0] blue;
    } pix_t;

    function automatic logic [4:0] msb_pos(input logic [MW-1:0] m);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < MW; i++) begin
            if (m[i]) p = 5'(i);
        end
        return p;
    endfunction

    function automatic logic [CW-1:0] clamp_cos(input logic signed [DW-1:0] s);
        logic [DW-1:0] q;
        logic [CW-1:0] res;
        q = (DW'(s) + DW'(HALF)) >> F;
        if (s <= 0) res = '0;
        else if (q > DW'(ONE)) res = CW'(ONE);
        else res = q[CW-1:0];
        return res;
    endfunction

    function automatic logic signed [RW-1:0] round_away(input logic signed [DW-1:0] v);
        logic [DW-1:0] mag;
        logic [DW-1:0] q;
        mag = v[DW-1] ? DW'(-v) : DW'(v);
        q = (mag + DW'(HALF)) >> F;
        return v[DW-1] ? -$signed(q[RW-1:0]) : $signed(q[RW-1:0]);
    endfunction

    function automatic unit_t clamp_unit(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] one_r;
        unit_t res;
        one_r = RW'(ONE);
        if (v > one_r) res = UW'(ONE);
        else if (v < -one_r) res = -UW'(ONE);
        else res = v[UW-1:0];
        return res;
    endfunction

    function automatic logic [CW-1:0] mul_f(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [PW-1:0] p;
        p = PW'(a) * PW'(b) + PW'(HALF);
        return CW'(p >> F);
    endfunction

    function automatic logic [CLW-1:0] gain_factor(input logic [CLW-1:0] g,
                                                   input logic [CW-1:0] c);
        logic [CLW+CW-1:0] p;
        p = (CLW+CW)'(g) * (CLW+CW)'(c) + (CLW+CW)'(HALF);
        return CLW'(p >> F);
    endfunction

    function automatic logic [TW-1:0] color_term(input logic [CLW-1:0] col,
                                                 input logic [CLW-1:0] f);
        logic [2*CLW-1:0] p;
        p = (2*CLW)'(col) * (2*CLW)'(f) + (2*CLW)'(CL_HALF);
        return TW'(p >> CL_SH);
    endfunction

endpackage

// ===== design/pls_norm.sv =====
// Pipelined vector normalizer: align, square sum, root, three-lane divide
module pls_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  logic           in_valid,
    input  pls_pkg::nvec_t vec,
    input  pls_pkg::ctx_t  side_in,
    output logic           out_valid,
    output pls_pkg::uvec_t unit,
    output pls_pkg::ctx_t  side_out
);
    import pls_pkg::*;

    typedef struct packed {
        logic [2:0][AW-1:0] a;
        logic [2:0]         neg;
        logic               zero;
        ctx_t               side;
    } car_t;

    // stage 1: magnitudes and largest one
    logic               v1_reg;
    logic [2:0][MW-1:0] mag1_reg;
    logic [2:0]         neg1_reg;
    logic [MW-1:0]      max1_reg;
    ctx_t               side1_reg;
    logic [2:0][MW-1:0] mag_next;
    logic [MW-1:0]      max_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = vec[i][NW-1] ? MW'(-vec[i]) : MW'(vec[i]);
        end
        max_next = mag_next[0];
        if (mag_next[1] > max_next) max_next = mag_next[1];
        if (mag_next[2] > max_next) max_next = mag_next[2];
    end

    // stage 2: shift all three until the largest reaches 2^29
    logic       v2_reg;
    car_t       c2_reg;
    car_t       c2_next;
    logic [4:0] sh;

    always_comb
    begin
        sh = 5'(TOPB) - msb_pos(max1_reg);
        c2_next.neg  = neg1_reg;
        c2_next.zero = (max1_reg == '0);
        c2_next.side = side1_reg;
        for (int i = 0; i < 3; i++) begin
            c2_next.a[i] = AW'(mag1_reg[i]) << sh;
        end
    end

    // stage 3: squares
    logic                 v3_reg;
    car_t                 c3_reg;
    logic [2*AW-1:0]      sq3_reg [3];

    // root pipeline
    logic [SQW-1:0] s_reg  [RT_N+1];
    logic [SQW-1:0] r_reg  [RT_N+1];
    car_t           rc_reg [RT_N+1];
    logic           rv_reg [RT_N+1];

    // divider pipeline
    logic [2:0][NUMW-1:0] rem_reg [QW+1];
    logic [2:0][QW-1:0]   q_reg   [QW+1];
    logic [LW-1:0]        den_reg [QW+1];
    car_t                 dc_reg  [QW+1];
    logic                 dv_reg  [QW+1];

    logic [2:0][NUMW-1:0] num_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            num_next[i] = (NUMW'(rc_reg[RT_N].a[i]) << F) + NUMW'(r_reg[RT_N] >> 1);
        end
    end

    // final stage
    logic  vo_reg;
    uvec_t unit_reg;
    ctx_t  so_reg;
    uvec_t unit_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            logic [QW-1:0] q;
            q = q_reg[QW][i];
            if (q > QW'(ONE)) q = QW'(ONE);
            if (dc_reg[QW].zero) unit_next[i] = '0;
            else if (dc_reg[QW].neg[i]) unit_next[i] = -$signed(UW'(q));
            else unit_next[i] = $signed(UW'(q));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            rv_reg[0] <= 1'b0;
            dv_reg[0] <= 1'b0;
            vo_reg    <= 1'b0;
        end else if (ce) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            rv_reg[0] <= v3_reg;
            dv_reg[0] <= rv_reg[RT_N];
            vo_reg    <= dv_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce) begin
            mag1_reg  <= mag_next;
            max1_reg  <= max_next;
            side1_reg <= side_in;
            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= vec[i][NW-1];
            end
            c2_reg <= c2_next;
            c3_reg <= c2_reg;
            for (int i = 0; i < 3; i++) begin
                sq3_reg[i] <= (2*AW)'(c2_reg.a[i]) * (2*AW)'(c2_reg.a[i]);
            end
            s_reg[0]  <= SQW'(sq3_reg[0]) + SQW'(sq3_reg[1]) + SQW'(sq3_reg[2]);
            r_reg[0]  <= '0;
            rc_reg[0] <= c3_reg;
            rem_reg[0] <= num_next;
            q_reg[0]   <= '0;
            den_reg[0] <= r_reg[RT_N][LW-1:0];
            dc_reg[0]  <= rc_reg[RT_N];
            unit_reg <= unit_next;
            so_reg   <= dc_reg[QW].side;
        end
    end

    genvar j;
    for (j = 0; j < RT_N; j++) begin : g_root
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (RT_N - 1 - j));
        logic [SQW-1:0] tr;
        logic [SQW-1:0] s_nx;
        logic [SQW-1:0] r_nx;

        always_comb
        begin
            tr = r_reg[j] + BIT;
            if (s_reg[j] >= tr) begin
                s_nx = s_reg[j] - tr;
                r_nx = (r_reg[j] >> 1) + BIT;
            end else begin
                s_nx = s_reg[j];
                r_nx = r_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) rv_reg[j+1] <= 1'b0;
            else if (ce) rv_reg[j+1] <= rv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (ce) begin
                s_reg[j+1]  <= s_nx;
                r_reg[j+1]  <= r_nx;
                rc_reg[j+1] <= rc_reg[j];
            end
        end
    end

    genvar k;
    for (k = 0; k < QW; k++) begin : g_div
        localparam int B = QW - 1 - k;
        logic [DVW-1:0]       trial;
        logic [2:0][NUMW-1:0] rem_nx;
        logic [2:0][QW-1:0]   q_nx;

        always_comb
        begin
            trial = DVW'(den_reg[k]) << B;
            for (int i = 0; i < 3; i++) begin
                rem_nx[i] = rem_reg[k][i];
                q_nx[i]   = q_reg[k][i];
                if (DVW'(rem_reg[k][i]) >= trial) begin
                    rem_nx[i]  = NUMW'(DVW'(rem_reg[k][i]) - trial);
                    q_nx[i][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) dv_reg[k+1] <= 1'b0;
            else if (ce) dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (ce) begin
                rem_reg[k+1] <= rem_nx;
                q_reg[k+1]   <= q_nx;
                den_reg[k+1] <= den_reg[k];
                dc_reg[k+1]  <= dc_reg[k];
            end
        end
    end

    assign out_valid = vo_reg;
    assign unit      = unit_reg;
    assign side_out  = so_reg;

endmodule

// ===== design/pls_spec.sv =====
// Dot products, Phong reflection and specular cosine select
module pls_spec (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ce,
    input  logic                   in_valid,
    input  pls_pkg::ctx_t          ctx,
    input  pls_pkg::uvec_t         hv,
    input  logic                   mode,
    output logic                   out_valid,
    output logic [pls_pkg::CW-1:0] ndotl,
    output logic [pls_pkg::CW-1:0] spec_cos
);
    import pls_pkg::*;

    logic vld_reg [7];

    logic signed [PRW-1:0] pnl1_reg [3];
    logic signed [PRW-1:0] pnh1_reg [3];
    ctx_t                  ctx1_reg;
    logic signed [DW-1:0]  dnl2_reg;
    logic signed [DW-1:0]  dnh2_reg;
    ctx_t                  ctx2_reg;
    logic [CW-1:0]         ndl3_reg, bl3_reg;
    unit_t                 d3_reg;
    ctx_t                  ctx3_reg;
    logic signed [DW-1:0]  pr4_reg [3];
    uvec_t                 ll4_reg, vv4_reg;
    logic [CW-1:0]         ndl4_reg, bl4_reg;
    uvec_t                 t5_reg, vv5_reg;
    logic [CW-1:0]         ndl5_reg, bl5_reg;
    logic signed [PRW-1:0] ptv6_reg [3];
    logic [CW-1:0]         ndl6_reg, bl6_reg;
    logic [CW-1:0]         ndl7_reg, spc7_reg;

    logic signed [DW-1:0]  phong_dot;

    always_comb
    begin
        phong_dot = DW'(ptv6_reg[0]) + DW'(ptv6_reg[1]) + DW'(ptv6_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 7; i++) vld_reg[i] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < 7; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                pnl1_reg[i] <= $signed(ctx.nn[i]) * $signed(ctx.ll[i]);
                pnh1_reg[i] <= $signed(ctx.nn[i]) * $signed(hv[i]);
            end
            ctx1_reg <= ctx;

            dnl2_reg <= DW'(pnl1_reg[0]) + DW'(pnl1_reg[1]) + DW'(pnl1_reg[2]);
            dnh2_reg <= DW'(pnh1_reg[0]) + DW'(pnh1_reg[1]) + DW'(pnh1_reg[2]);
            ctx2_reg <= ctx1_reg;

            ndl3_reg <= clamp_cos(dnl2_reg);
            bl3_reg  <= clamp_cos(dnh2_reg);
            d3_reg   <= clamp_unit(round_away(dnl2_reg));
            ctx3_reg <= ctx2_reg;

            for (int i = 0; i < 3; i++) begin
                pr4_reg[i] <= DW'($signed(d3_reg) * $signed(ctx3_reg.nn[i])) <<< 1;
            end
            ll4_reg  <= ctx3_reg.ll;
            vv4_reg  <= ctx3_reg.vv;
            ndl4_reg <= ndl3_reg;
            bl4_reg  <= bl3_reg;

            for (int i = 0; i < 3; i++) begin
                t5_reg[i] <= clamp_unit(round_away(pr4_reg[i]) - RW'($signed(ll4_reg[i])));
            end
            vv5_reg  <= vv4_reg;
            ndl5_reg <= ndl4_reg;
            bl5_reg  <= bl4_reg;

            for (int i = 0; i < 3; i++) begin
                ptv6_reg[i] <= $signed(t5_reg[i]) * $signed(vv5_reg[i]);
            end
            ndl6_reg <= ndl5_reg;
            bl6_reg  <= bl5_reg;

            ndl7_reg <= ndl6_reg;
            spc7_reg <= (mode == MODEL_PHONG) ? clamp_cos(phong_dot) : bl6_reg;
        end
    end

    assign out_valid = vld_reg[6];
    assign ndotl     = ndl7_reg;
    assign spec_cos  = spc7_reg;

endmodule

// ===== design/pls_pow.sv =====
// Integer power of the specular cosine, one exponent bit per stage
module pls_pow (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ce,
    input  logic                   in_valid,
    input  logic [pls_pkg::CW-1:0] base,
    input  logic [pls_pkg::CW-1:0] ndotl_in,
    input  logic [pls_pkg::EB-1:0] expo,
    output logic                   out_valid,
    output logic [pls_pkg::CW-1:0] power,
    output logic [pls_pkg::CW-1:0] ndotl_out
);
    import pls_pkg::*;

    logic          v_reg   [EB+1];
    logic [CW-1:0] r_reg   [EB+1];
    logic [CW-1:0] x_reg   [EB+1];
    logic [CW-1:0] ndl_reg [EB+1];

    always_comb
    begin
        v_reg[0]   = in_valid;
        r_reg[0]   = CW'(ONE);
        x_reg[0]   = base;
        ndl_reg[0] = ndotl_in;
    end

    genvar i;
    for (i = 0; i < EB; i++) begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_reg[i+1] <= 1'b0;
            else if (ce) v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (ce) begin
                r_reg[i+1]   <= expo[i] ? mul_f(r_reg[i], x_reg[i]) : r_reg[i];
                x_reg[i+1]   <= mul_f(x_reg[i], x_reg[i]);
                ndl_reg[i+1] <= ndl_reg[i];
            end
        end
    end

    assign out_valid = v_reg[EB];
    assign power     = r_reg[EB];
    assign ndotl_out = ndl_reg[EB];

endmodule

// ===== design/pls_mix.sv =====
// Ambient, diffuse and specular terms per channel with saturation
module pls_mix (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ce,
    input  logic                   in_valid,
    input  logic [pls_pkg::CW-1:0] ndotl,
    input  logic [pls_pkg::CW-1:0] spw,
    input  pls_pkg::cfg_t          cfg,
    output logic                   out_valid,
    output pls_pkg::pix_t          pix
);
    import pls_pkg::*;

    logic           vld_reg [3];
    logic [CLW-1:0] fa_reg, fd_reg, fs_reg;
    logic [TW-1:0]  ta_reg [3];
    logic [TW-1:0]  td_reg [3];
    logic [TW-1:0]  ts_reg [3];
    logic [CLW-1:0] ch_next [3];
    pix_t           pix_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++) begin
            logic [SUMW-1:0] s;
            s = SUMW'(ta_reg[c]) + SUMW'(td_reg[c]) + SUMW'(ts_reg[c]);
            ch_next[c] = (s > SUMW'(ONE)) ? CLW'(ONE) : s[CLW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 3; i++) vld_reg[i] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= in_valid;
            vld_reg[1] <= vld_reg[0];
            vld_reg[2] <= vld_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce) begin
            fa_reg <= gain_factor(cfg.amb_gain, CW'(ONE));
            fd_reg <= gain_factor(cfg.dif_gain, ndotl);
            fs_reg <= gain_factor(cfg.spc_gain, spw);
            for (int c = 0; c < 3; c++) begin
                ta_reg[c] <= color_term(cfg.amb_color[CLW*c +: CLW], fa_reg);
                td_reg[c] <= color_term(cfg.dif_color[CLW*c +: CLW], fd_reg);
                ts_reg[c] <= color_term(cfg.spc_color[CLW*c +: CLW], fs_reg);
            end
            pix_reg.red   <= ch_next[0];
            pix_reg.green <= ch_next[1];
            pix_reg.blue  <= ch_next[2];
        end
    end

    assign out_valid = vld_reg[2];
    assign pix       = pix_reg;

endmodule

// ===== design/point_lighting_shader.sv =====
// Top level of the per-pixel point lighting shader (Blinn or Phong specular)
//
// Usage:
//   frag channel: one fragment beat per cycle (normal, light and eye vectors,
//     any scale). A beat moves when frag_valid is high and frag_stall is low.
//   pix channel: one shaded RGB beat per fragment, Q1.15, saturated at 1.0,
//     in fragment order. A beat moves when pix_valid is high and pix_stall low.
//   APB port: eight 64-bit registers at byte address 8*i; write them only
//     while no fragment is in flight. pready is tied high.
// Pipeline: two 55-stage normalizer passes in series (32-step square root,
//   17-step divide), 7 stages of dot products and reflection, 10 stages of
//   exponentiation (one exponent bit each), 3 stages of color mixing.
// Throughput: one fragment per cycle while no stalled pixel beat holds the pipeline.
// Stall: a stalled pixel beat freezes the whole pipeline in place and raises
//   frag_stall in the same cycle; nothing is dropped or repeated.
// Reset: all valid bits clear, configuration registers go to zero except the
//   exponent, which resets to 32 (Blinn model selected).
`include "point_lighting_shader_macros.svh"
module point_lighting_shader (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [5:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready,
    input  logic           frag_valid,
    output logic           frag_stall,
    input  pls_pkg::frag_t frag,
    output logic           pix_valid,
    input  logic           pix_stall,
    output pls_pkg::pix_t  pix
);
    import pls_pkg::*;

    // configuration registers
    logic [3*CLW-1:0] amb_color_reg, dif_color_reg, spc_color_reg;
    logic [CLW-1:0]   amb_gain_reg, dif_gain_reg, spc_gain_reg;
    logic [9:0]       exponent_reg;
    logic             model_reg;
    logic             wr_en;
    logic [2:0]       wr_idx;
    cfg_t             cfg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            amb_color_reg <= '0;
            dif_color_reg <= '0;
            spc_color_reg <= '0;
            amb_gain_reg  <= '0;
            dif_gain_reg  <= '0;
            spc_gain_reg  <= '0;
            exponent_reg  <= 10'd32;
            model_reg     <= MODEL_BLINN;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_AMB_COLOR: amb_color_reg <= pwdata[3*CLW-1:0];
                REG_DIF_COLOR: dif_color_reg <= pwdata[3*CLW-1:0];
                REG_SPC_COLOR: spc_color_reg <= pwdata[3*CLW-1:0];
                REG_AMB_GAIN:  amb_gain_reg  <= pwdata[CLW-1:0];
                REG_DIF_GAIN:  dif_gain_reg  <= pwdata[CLW-1:0];
                REG_SPC_GAIN:  spc_gain_reg  <= pwdata[CLW-1:0];
                REG_EXPONENT:  exponent_reg  <= pwdata[9:0];
                REG_MODEL:     model_reg     <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_AMB_COLOR: prdata = 64'(amb_color_reg);
            REG_DIF_COLOR: prdata = 64'(dif_color_reg);
            REG_SPC_COLOR: prdata = 64'(spc_color_reg);
            REG_AMB_GAIN:  prdata = 64'(amb_gain_reg);
            REG_DIF_GAIN:  prdata = 64'(dif_gain_reg);
            REG_SPC_GAIN:  prdata = 64'(spc_gain_reg);
            REG_EXPONENT:  prdata = 64'(exponent_reg);
            REG_MODEL:     prdata = 64'(model_reg);
        endcase
    end

    always_comb
    begin
        cfg.amb_color = amb_color_reg;
        cfg.dif_color = dif_color_reg;
        cfg.spc_color = spc_color_reg;
        cfg.amb_gain  = amb_gain_reg;
        cfg.dif_gain  = dif_gain_reg;
        cfg.spc_gain  = spc_gain_reg;
    end

    // whole pipeline advances unless the output beat is held
    logic ce;
    assign ce         = !(pix_valid && pix_stall);
    assign frag_stall = !ce;

    // first pass: normalize N, L and V side by side
    nvec_t n_in, l_in, e_in;
    uvec_t nn, ll, vv;
    logic  p1_valid;

    always_comb
    begin
        n_in[0] = NW'(frag.normal_x);
        n_in[1] = NW'(frag.normal_y);
        n_in[2] = NW'(frag.normal_z);
        l_in[0] = NW'(frag.light_x);
        l_in[1] = NW'(frag.light_y);
        l_in[2] = NW'(frag.light_z);
        e_in[0] = NW'(frag.eye_x);
        e_in[1] = NW'(frag.eye_y);
        e_in[2] = NW'(frag.eye_z);
    end

    pls_norm u_norm_n (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(frag_valid && ce),
        .vec(n_in), .side_in('0),
        .out_valid(p1_valid), .unit(nn), .side_out()
    );

    pls_norm u_norm_l (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(frag_valid && ce),
        .vec(l_in), .side_in('0),
        .out_valid(), .unit(ll), .side_out()
    );

    pls_norm u_norm_v (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(frag_valid && ce),
        .vec(e_in), .side_in('0),
        .out_valid(), .unit(vv), .side_out()
    );

    // second pass: half vector L+V, with N, L, V carried alongside
    nvec_t h_in;
    ctx_t  ctx_in, ctx_out;
    uvec_t hh;
    logic  p2_valid;

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            h_in[i] = NW'($signed(ll[i])) + NW'($signed(vv[i]));
        end
        ctx_in.nn = nn;
        ctx_in.ll = ll;
        ctx_in.vv = vv;
    end

    pls_norm u_norm_h (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(p1_valid),
        .vec(h_in), .side_in(ctx_in),
        .out_valid(p2_valid), .unit(hh), .side_out(ctx_out)
    );

    logic          sp_valid;
    logic [CW-1:0] sp_ndotl, sp_cos;

    pls_spec u_spec (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(p2_valid),
        .ctx(ctx_out), .hv(hh), .mode(model_reg),
        .out_valid(sp_valid), .ndotl(sp_ndotl), .spec_cos(sp_cos)
    );

    logic          pw_valid;
    logic [CW-1:0] pw_val, pw_ndotl;

    pls_pow u_pow (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(sp_valid),
        .base(sp_cos), .ndotl_in(sp_ndotl), .expo(exponent_reg[EB-1:0]),
        .out_valid(pw_valid), .power(pw_val), .ndotl_out(pw_ndotl)
    );

    pls_mix u_mix (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(pw_valid),
        .ndotl(pw_ndotl), .spw(pw_val), .cfg(cfg),
        .out_valid(pix_valid), .pix(pix)
    );

    `PLS_ASSERT_SAME(a_stall_back, pix_valid && pix_stall, frag_stall)
    `PLS_ASSERT_SAME(a_no_stall_empty, !pix_valid, !frag_stall)
    `PLS_ASSERT_SAME(a_saturated, pix_valid, pix.red <= CLW'(ONE) && pix.green <= CLW'(ONE) && pix.blue <= CLW'(ONE))
    `PLS_ASSERT_NEXT(a_exp_write, wr_en && wr_idx == REG_EXPONENT, exponent_reg == $past(pwdata[9:0]))

endmodule
